// File: hw/rtl/lr3b2_pkg.sv
// Shared command and status types for the limb reciprocal block.
`timescale 1ns / 1ps
`default_nettype none

package lr3b2_pkg;

   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic normalized;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/limb_reciprocal_3by2_core.sv
// Top level of the two-limb reciprocal unit for 3-by-2 division.
`timescale 1ns / 1ps
`default_nettype none

// Computes floor((2^(3*LIMB_WIDTH)-1) / (high*2^LIMB_WIDTH + low)) - 2^LIMB_WIDTH by
// restoring division, one quotient bit per cycle through one 2*LIMB_WIDTH-bit subtractor.
// A transaction is taken when start is high and busy is low. For a normalized divisor
// rsp_valid rises at the edge that ends the last division step and the result is taken
// at the edge that ends that cycle. Busy falls together with the rise of rsp_valid, so the
// next transaction can be accepted at the edge that ends the rsp_valid cycle; throughput
// is set by the bit-serial division. An unnormalized divisor raises rsp_valid at the edge
// that follows the accepting edge, with rsp_not_normalized set and a zero reciprocal.
// The receiver cannot stall: rsp_valid lasts one cycle and the result ports hold until the
// next transaction is accepted.
module limb_reciprocal_3by2_core #(
   parameter int LIMB_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [LIMB_WIDTH-1:0] req_divisor_high,
   input  wire logic [LIMB_WIDTH-1:0] req_divisor_low,
   output logic                       rsp_valid,
   output logic [LIMB_WIDTH-1:0]      rsp_reciprocal,
   output logic                       rsp_not_normalized
);

   lr3b2_pkg::dp_cmd_type    dp_cmd;
   lr3b2_pkg::dp_status_type dp_status;

   lr3b2_ctrl #(
      .LIMB_WIDTH(LIMB_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   lr3b2_datapath #(
      .LIMB_WIDTH(LIMB_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .divisor_high   (req_divisor_high),
      .divisor_low    (req_divisor_low),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .reciprocal     (rsp_reciprocal),
      .not_normalized (rsp_not_normalized)
   );

endmodule

`default_nettype wire

// File: hw/rtl/lr3b2_ctrl.sv
// Controller state machine that sequences the bit-serial division.
`timescale 1ns / 1ps
`default_nettype none

module lr3b2_ctrl #(
   parameter int LIMB_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   output lr3b2_pkg::dp_cmd_type       dp_cmd,
   input  wire lr3b2_pkg::dp_status_type dp_status
);

   localparam int STEPS = 3 * LIMB_WIDTH;
   localparam int CNT_W = $clog2(STEPS);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             rsp_valid_ff;

   always_comb begin
      dp_cmd.load = (state_ff == ST_IDLE) && start && !busy_ff;
      dp_cmd.step = (state_ff == ST_RUN) && dp_status.normalized;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start && !busy_ff) begin
                  state_ff <= ST_RUN;
                  cnt_ff   <= '0;
                  busy_ff  <= 1'b1;
               end
            end
            ST_RUN: begin
               if (!dp_status.normalized || cnt_ff == CNT_W'(STEPS - 1)) begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lr3b2_datapath.sv
// Datapath holding the divisor, partial remainder and quotient of the restoring division.
`timescale 1ns / 1ps
`default_nettype none

module lr3b2_datapath #(
   parameter int LIMB_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic [LIMB_WIDTH-1:0]   divisor_high,
   input  wire logic [LIMB_WIDTH-1:0]   divisor_low,
   input  wire lr3b2_pkg::dp_cmd_type   dp_cmd,
   output lr3b2_pkg::dp_status_type     dp_status,
   output logic [LIMB_WIDTH-1:0]        reciprocal,
   output logic                         not_normalized
);

   localparam int W2 = 2 * LIMB_WIDTH;

   logic [W2-1:0]         div_ff;
   logic [W2-1:0]         rem_ff;
   logic [LIMB_WIDTH-1:0] quo_ff;

   logic                  carry;
   logic [W2-1:0]         rem_shift;
   logic [W2:0]           diff;
   logic                  ge;

   always_comb begin
      carry     = rem_ff[W2-1];
      rem_shift = {rem_ff[W2-2:0], 1'b1};
      diff      = {1'b0, rem_shift} - {1'b0, div_ff};
      ge        = carry || !diff[W2];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         div_ff <= {divisor_high, divisor_low};
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (dp_cmd.step) begin
         rem_ff <= ge ? diff[W2-1:0] : rem_shift;
         quo_ff <= {quo_ff[LIMB_WIDTH-2:0], ge};
      end
   end

   assign dp_status.normalized = div_ff[W2-1];
   assign reciprocal           = quo_ff;
   assign not_normalized       = !div_ff[W2-1];

endmodule

`default_nettype wire
